// ----- src/fte_pkg.sv -----
// fte_pkg: shared types and constants for the flow tuple extractor.
// Holds ethertype values, header offsets, protocol numbers and status codes.
// No dependencies.
package fte_pkg;

    localparam int unsigned OFFSET_W = 7;

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86dd;
    localparam logic [3:0]  IHL_MASK = 4'hf;

    // byte offsets and lengths: the first five count from the start of the frame, the rest from the IP header
    localparam logic [OFFSET_W-1:0] OFF_ETYPE_HI  = 7'd12;
    localparam logic [OFFSET_W-1:0] OFF_ETYPE_LO  = 7'd13;
    localparam logic [OFFSET_W-1:0] L3_START      = 7'd14;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX    = 7'd127;
    localparam logic [OFFSET_W-1:0] TS_DEFAULT    = 7'd34;
    localparam logic [OFFSET_W-1:0] V6_HDR_LEN    = 7'd40;
    localparam logic [OFFSET_W-1:0] V6_DST_OFF    = 7'd24;
    localparam logic [OFFSET_W-1:0] V4_PROTO_OFF  = 7'd9;
    localparam logic [OFFSET_W-1:0] V6_PROTO_OFF  = 7'd6;
    localparam logic [OFFSET_W-1:0] V4_SRC_OFF    = 7'd12;
    localparam logic [OFFSET_W-1:0] V4_DST_OFF    = 7'd16;
    localparam logic [OFFSET_W-1:0] V6_SRC_OFF    = 7'd8;
    localparam logic [OFFSET_W-1:0] ADDR_BYTES    = 7'd4;
    localparam logic [3:0]          IHL_MIN       = 4'd5;

    // layer-4 protocol numbers
    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_DCCP   = 8'd33;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;
    localparam logic [7:0] PROTO_SCTP   = 8'd132;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ETYPE = 2'd1,
        ST_BAD_PROTO = 2'd2,
        ST_MALFORMED = 2'd3
    } t_status;

endpackage

// ----- src/flow_tuple_extractor.sv -----
// flow_tuple_extractor: Ethernet/IP five-tuple header parser, top level.
// Depends on fte_pkg for constants and the status type.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one frame byte per item,
//   starting at the destination MAC; i_last_byte marks the final byte.
//   Output channel (o_out_valid / i_out_ready) carries one result per frame,
//   made on the last byte: status, protocol, first address words, ports (or
//   ICMP type/code) and a running frame number starting at 1.
//   The result is on the output register in the cycle after the last byte
//   is accepted. Throughput: one byte per cycle, back to back unless a last
//   byte waits on a pending result, set by the single capture/decode stage
//   between the parser state registers and the result register.
//   Stall: while a result waits unaccepted, non-last bytes of the next frame
//   still enter; a last byte waits until the result register frees (it frees
//   in the same cycle it is taken).
//   Bytes at offset 127 and beyond are ignored.
//   Reset (i_rst_n low, synchronous) clears the parser state, the frame
//   count and the output valid.
module flow_tuple_extractor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_protocol,
    output logic [31:0] o_src_address,
    output logic [31:0] o_dst_address,
    output logic [15:0] o_src_port,
    output logic [15:0] o_dst_port,
    output logic [31:0] o_frame_number
);

    localparam int unsigned OW = fte_pkg::OFFSET_W;

    // parser state
    logic [OW-1:0] r_offset, n_offset;
    logic [15:0]   r_ether, n_ether;
    logic [OW-1:0] r_ts, n_ts;
    logic [7:0]    r_proto, n_proto;
    logic [31:0]   r_src, n_src;
    logic [31:0]   r_dst, n_dst;
    logic [15:0]   r_port_a, n_port_a;
    logic [15:0]   r_port_b, n_port_b;
    logic          r_short_ihl, n_short_ihl;
    logic [31:0]   r_frame_count;

    // result register
    logic          r_out_valid;
    logic [1:0]    r_status;
    logic [7:0]    r_protocol;
    logic [31:0]   r_src_address, r_dst_address, r_frame_number;
    logic [15:0]   r_src_port, r_dst_port;

    logic          in_acc, out_free, take, in_l3, is_v4, is_v6, icmp, port_proto;
    logic [OW-1:0] o_off, rel, proto_off;
    logic [OW:0]   ts_end, need_end;
    logic [3:0]    ihl;
    fte_pkg::t_status res_status;
    logic [7:0]    res_proto;
    logic [31:0]   res_src, res_dst;
    logic [15:0]   res_sp, res_dp;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = out_free || !i_last_byte;
    assign in_acc     = i_in_valid && o_in_ready;

    assign o_off = r_offset;
    assign take  = o_off != fte_pkg::OFFSET_MAX;
    assign in_l3 = o_off >= fte_pkg::L3_START;
    assign ihl   = i_frame_byte[3:0] & fte_pkg::IHL_MASK;

    // per-byte capture
    always_comb begin
        n_offset    = take ? r_offset + 7'd1 : r_offset;
        n_ether     = r_ether;
        n_ts        = r_ts;
        n_proto     = r_proto;
        n_src       = r_src;
        n_dst       = r_dst;
        n_short_ihl = r_short_ihl;
        if (take && (o_off == fte_pkg::OFF_ETYPE_HI || o_off == fte_pkg::OFF_ETYPE_LO)) begin
            n_ether = {r_ether[7:0], i_frame_byte};
        end
        if (take && in_l3 && n_ether == fte_pkg::ETH_IPV4) begin
            if (o_off == fte_pkg::L3_START) begin
                n_ts        = fte_pkg::L3_START + {1'b0, ihl, 2'b00};
                n_short_ihl = ihl < fte_pkg::IHL_MIN;
            end
            if (o_off == fte_pkg::L3_START + fte_pkg::V4_PROTO_OFF) begin
                n_proto = i_frame_byte;
            end
            if (o_off >= fte_pkg::L3_START + fte_pkg::V4_SRC_OFF &&
                o_off <  fte_pkg::L3_START + fte_pkg::V4_SRC_OFF + fte_pkg::ADDR_BYTES) begin
                n_src = {r_src[23:0], i_frame_byte};
            end
            if (o_off >= fte_pkg::L3_START + fte_pkg::V4_DST_OFF &&
                o_off <  fte_pkg::L3_START + fte_pkg::V4_DST_OFF + fte_pkg::ADDR_BYTES) begin
                n_dst = {r_dst[23:0], i_frame_byte};
            end
        end else if (take && in_l3 && n_ether == fte_pkg::ETH_IPV6) begin
            if (o_off == fte_pkg::L3_START) begin
                n_ts = fte_pkg::L3_START + fte_pkg::V6_HDR_LEN;
            end
            if (o_off == fte_pkg::L3_START + fte_pkg::V6_PROTO_OFF) begin
                n_proto = i_frame_byte;
            end
            if (o_off >= fte_pkg::L3_START + fte_pkg::V6_SRC_OFF &&
                o_off <  fte_pkg::L3_START + fte_pkg::V6_SRC_OFF + fte_pkg::ADDR_BYTES) begin
                n_src = {r_src[23:0], i_frame_byte};
            end
            if (o_off >= fte_pkg::L3_START + fte_pkg::V6_DST_OFF &&
                o_off <  fte_pkg::L3_START + fte_pkg::V6_DST_OFF + fte_pkg::ADDR_BYTES) begin
                n_dst = {r_dst[23:0], i_frame_byte};
            end
        end
    end

    assign ts_end = {1'b0, n_ts} + 8'd4;
    assign rel    = o_off - n_ts;

    // transport start may have been set by this same byte (IHL of zero)
    always_comb begin
        n_port_a = r_port_a;
        n_port_b = r_port_b;
        if (take && in_l3 && o_off >= n_ts && {1'b0, o_off} < ts_end) begin
            if (rel < 7'd2) begin
                n_port_a = {r_port_a[7:0], i_frame_byte};
            end else begin
                n_port_b = {r_port_b[7:0], i_frame_byte};
            end
        end
    end

    // end-of-frame decode
    assign is_v4      = n_ether == fte_pkg::ETH_IPV4;
    assign is_v6      = n_ether == fte_pkg::ETH_IPV6;
    assign proto_off  = is_v6 ? fte_pkg::L3_START + fte_pkg::V6_PROTO_OFF
                              : fte_pkg::L3_START + fte_pkg::V4_PROTO_OFF;
    assign icmp       = n_proto == fte_pkg::PROTO_ICMP ||
                        (is_v6 && n_proto == fte_pkg::PROTO_ICMPV6);
    assign port_proto = n_proto == fte_pkg::PROTO_TCP  || n_proto == fte_pkg::PROTO_UDP ||
                        n_proto == fte_pkg::PROTO_DCCP || n_proto == fte_pkg::PROTO_SCTP;
    assign need_end   = {1'b0, n_ts} + (icmp ? 8'd1 : 8'd3);

    always_comb begin
        res_status = fte_pkg::ST_OK;
        res_proto  = '0;
        res_src    = '0;
        res_dst    = '0;
        res_sp     = '0;
        res_dp     = '0;
        if (o_off < fte_pkg::OFF_ETYPE_LO) begin
            res_status = fte_pkg::ST_MALFORMED;
        end else if (!is_v4 && !is_v6) begin
            res_status = fte_pkg::ST_BAD_ETYPE;
        end else if (!is_v6 && (!in_l3 || n_short_ihl)) begin
            res_status = fte_pkg::ST_MALFORMED;
        end else if (o_off < proto_off) begin
            res_status = fte_pkg::ST_MALFORMED;
        end else if (!icmp && !port_proto) begin
            res_status = fte_pkg::ST_BAD_PROTO;
            res_proto  = n_proto;
        end else if ({1'b0, o_off} < need_end) begin
            res_status = fte_pkg::ST_MALFORMED;
        end else begin
            res_proto = n_proto;
            res_src   = n_src;
            res_dst   = n_dst;
            if (icmp) begin
                res_sp = {8'd0, n_port_a[15:8]};
                res_dp = {8'd0, n_port_a[7:0]};
            end else begin
                res_sp = n_port_a;
                res_dp = n_port_b;
            end
        end
    end

    // control and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset      <= '0;
            r_ether       <= '0;
            r_ts          <= fte_pkg::TS_DEFAULT;
            r_proto       <= '0;
            r_src         <= '0;
            r_dst         <= '0;
            r_port_a      <= '0;
            r_port_b      <= '0;
            r_short_ihl   <= 1'b0;
            r_frame_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_acc && i_last_byte) begin
                r_offset      <= '0;
                r_ether       <= '0;
                r_ts          <= fte_pkg::TS_DEFAULT;
                r_proto       <= '0;
                r_src         <= '0;
                r_dst         <= '0;
                r_port_a      <= '0;
                r_port_b      <= '0;
                r_short_ihl   <= 1'b0;
                r_frame_count <= r_frame_count + 32'd1;
            end else if (in_acc) begin
                r_offset    <= n_offset;
                r_ether     <= n_ether;
                r_ts        <= n_ts;
                r_proto     <= n_proto;
                r_src       <= n_src;
                r_dst       <= n_dst;
                r_port_a    <= n_port_a;
                r_port_b    <= n_port_b;
                r_short_ihl <= n_short_ihl;
            end
            if (in_acc && i_last_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_acc && i_last_byte) begin
            r_status       <= res_status;
            r_protocol     <= res_proto;
            r_src_address  <= res_src;
            r_dst_address  <= res_dst;
            r_src_port     <= res_sp;
            r_dst_port     <= res_dp;
            r_frame_number <= r_frame_count + 32'd1;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_protocol     = r_protocol;
    assign o_src_address  = r_src_address;
    assign o_dst_address  = r_dst_address;
    assign o_src_port     = r_src_port;
    assign o_dst_port     = r_dst_port;
    assign o_frame_number = r_frame_number;

    // a finished frame always leaves the parser at offset zero
    a_offset_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last_byte |=> r_offset == '0)
        else $error("offset not cleared after last byte");

    // each frame bumps the count by exactly one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last_byte |=> r_frame_count == $past(r_frame_count) + 32'd1)
        else $error("frame count step wrong");

    // a new result only appears after a last byte was taken
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_acc && i_last_byte))
        else $error("result without last byte");

    // failed frames carry no addresses or ports
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != fte_pkg::ST_OK |->
            o_src_address == '0 && o_dst_address == '0 &&
            o_src_port == '0 && o_dst_port == '0)
        else $error("nonzero fields on failed frame");

    // a pending unaccepted result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !(in_acc && i_last_byte))
        else $error("result overwritten");

endmodule

// ----- verif/flow_tuple_extractor_tb.sv -----
// flow_tuple_extractor_tb: self-checking testbench for the Ethernet/IP five-tuple parser.
// Sends directed and random frames byte by byte and checks each result against a predictor.
// Depends on fte_pkg and flow_tuple_extractor.
`timescale 1ns / 100ps

module flow_tuple_extractor_tb;
    import fte_pkg::*;

    localparam int TOTAL_BYTES  = 1600;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE       = 4;

    typedef struct packed {
        t_status     status;
        logic [7:0]  protocol;
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] frame_number;
    } t_tuple;

    // Predicts the tuple of each frame and holds the tuples still to come out.
    class t_tuple_scoreboard;
        t_tuple      expected_tuples[$];
        int          errors;
        int          status_tally[4];
        logic [6:0]  pos;
        logic [15:0] etype;
        logic [6:0]  l4_start;
        logic [7:0]  l4_proto;
        logic [31:0] src_word;
        logic [31:0] dst_word;
        logic [15:0] port_hi;
        logic [15:0] port_lo;
        logic [31:0] frame_cnt;
        bit          ihl_short;

        function new();
            clear_parser();
            frame_cnt = '0;
            errors = 0;
            foreach (status_tally[i]) status_tally[i] = 0;
        endfunction

        function void clear_parser();
            pos      = '0;
            etype    = '0;
            l4_start = TS_DEFAULT;
            l4_proto = '0;
            src_word = '0;
            dst_word = '0;
            port_hi  = '0;
            port_lo  = '0;
            ihl_short = 1'b0;
        endfunction

        function void parse_header_byte(int o, logic [7:0] b);
            if (o == OFF_ETYPE_HI || o == OFF_ETYPE_LO)
                etype = {etype[7:0], b};
            if (etype == ETH_IPV4 && o >= L3_START) begin
                if (o == L3_START) begin
                    l4_start  = 7'(L3_START + 4 * (b[3:0] & IHL_MASK));
                    ihl_short = (b[3:0] & IHL_MASK) < IHL_MIN;
                end
                if (o == L3_START + V4_PROTO_OFF)
                    l4_proto = b;
                if (o >= L3_START + V4_SRC_OFF && o < L3_START + V4_SRC_OFF + ADDR_BYTES)
                    src_word = {src_word[23:0], b};
                if (o >= L3_START + V4_DST_OFF && o < L3_START + V4_DST_OFF + ADDR_BYTES)
                    dst_word = {dst_word[23:0], b};
            end else if (etype == ETH_IPV6 && o >= L3_START) begin
                if (o == L3_START)
                    l4_start = L3_START + V6_HDR_LEN;
                if (o == L3_START + V6_PROTO_OFF)
                    l4_proto = b;
                if (o >= L3_START + V6_SRC_OFF && o < L3_START + V6_SRC_OFF + ADDR_BYTES)
                    src_word = {src_word[23:0], b};
                if (o >= L3_START + V6_DST_OFF && o < L3_START + V6_DST_OFF + ADDR_BYTES)
                    dst_word = {dst_word[23:0], b};
            end
            // first four transport bytes: two ports, or ICMP type then code
            if (o >= L3_START && o >= l4_start && o < l4_start + 4) begin
                if (o - l4_start < 2)
                    port_hi = {port_hi[7:0], b};
                else
                    port_lo = {port_lo[7:0], b};
            end
        endfunction

        function void note_frame_byte(logic [7:0] b, logic last);
            int     o;
            int     proto_at;
            bit     v6;
            bit     icmp;
            bit     port_kind;
            t_tuple t;
            o = pos;
            if (o < OFFSET_MAX)
                parse_header_byte(o, b);
            if (pos < OFFSET_MAX)
                pos = pos + 7'd1;
            if (!last)
                return;

            frame_cnt = frame_cnt + 32'd1;
            t = '0;
            t.frame_number = frame_cnt;
            if (o < OFF_ETYPE_LO) begin
                t.status = ST_MALFORMED;
            end else if (etype != ETH_IPV4 && etype != ETH_IPV6) begin
                t.status = ST_BAD_ETYPE;
            end else begin
                v6 = etype == ETH_IPV6;
                proto_at = v6 ? L3_START + V6_PROTO_OFF : L3_START + V4_PROTO_OFF;
                if (!v6 && (o < L3_START || ihl_short)) begin
                    t.status = ST_MALFORMED;
                end else if (o < proto_at) begin
                    t.status = ST_MALFORMED;
                end else begin
                    icmp = l4_proto == PROTO_ICMP || (v6 && l4_proto == PROTO_ICMPV6);
                    case (l4_proto)
                        PROTO_TCP, PROTO_UDP, PROTO_DCCP, PROTO_SCTP: port_kind = 1'b1;
                        default: port_kind = 1'b0;
                    endcase
                    if (!icmp && !port_kind) begin
                        t.status   = ST_BAD_PROTO;
                        t.protocol = l4_proto;
                    end else if (o < l4_start + (icmp ? 1 : 3)) begin
                        t.status = ST_MALFORMED;
                    end else begin
                        t.status      = ST_OK;
                        t.protocol    = l4_proto;
                        t.src_address = src_word;
                        t.dst_address = dst_word;
                        if (icmp) begin
                            t.src_port = {8'h00, port_hi[15:8]};
                            t.dst_port = {8'h00, port_hi[7:0]};
                        end else begin
                            t.src_port = port_hi;
                            t.dst_port = port_lo;
                        end
                    end
                end
            end
            status_tally[t.status]++;
            expected_tuples.insert(expected_tuples.size(), t);
            clear_parser();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function void check_tuple(t_tuple got);
            t_tuple want;
            if (expected_tuples.size() == 0) begin
                flag($sformatf("unexpected result: st=%0d fn=%0d", got.status, got.frame_number));
                return;
            end
            want = expected_tuples.pop_front();
            if (got.status != want.status || got.protocol != want.protocol ||
                got.src_address != want.src_address || got.dst_address != want.dst_address ||
                got.src_port != want.src_port || got.dst_port != want.dst_port ||
                got.frame_number != want.frame_number)
                flag($sformatf({"mismatch frame %0d: exp st=%0d pr=%0d src=%h dst=%h sp=%h",
                                " dp=%h fn=%0d, got st=%0d pr=%0d src=%h dst=%h sp=%h dp=%h",
                                " fn=%0d"},
                               want.frame_number, want.status, want.protocol,
                               want.src_address, want.dst_address, want.src_port,
                               want.dst_port, want.frame_number, got.status, got.protocol,
                               got.src_address, got.dst_address, got.src_port,
                               got.dst_port, got.frame_number));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_frame_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [7:0]  o_protocol;
    logic [31:0] o_src_address;
    logic [31:0] o_dst_address;
    logic [15:0] o_src_port;
    logic [15:0] o_dst_port;
    logic [31:0] o_frame_number;

    t_tuple_scoreboard sb;
    logic [7:0]        frame_bytes[$];
    int                burst_left = 0;
    int                bytes_sent = 0;
    int                frames_sent = 0;
    bit                hold_out = 1'b0;

    flow_tuple_extractor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_frame_byte   (i_frame_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_protocol     (o_protocol),
        .o_src_address  (o_src_address),
        .o_dst_address  (o_dst_address),
        .o_src_port     (o_src_port),
        .o_dst_port     (o_dst_port),
        .o_frame_number (o_frame_number)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Handshakes are sampled at the falling edge, where every signal is settled.
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_tuple('{t_status'(o_status), o_protocol, o_src_address, o_dst_address,
                             o_src_port, o_dst_port, o_frame_number});
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        forever begin
            @(negedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle = 0;
            else
                idle++;
            if (idle >= STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("FAIL flow_tuple_extractor");
                $finish;
            end
        end
    end

    // Result side: modes of random length, plus one long hold on request.
    initial begin : result_stall
        int         mode;
        int         mode_left;
        int         tick;
        logic [7:0] pattern;
        mode_left = 0;
        mode = 0;
        tick = 0;
        pattern = 8'hff;
        forever begin
            @(posedge i_clk);
            if (hold_out) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_out = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
                pattern   = 8'($urandom_range(0, 255));
            end
            mode_left--;
            tick++;
            case (mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= 1'($urandom_range(0, 1));
                2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= pattern[tick % 8];
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_frame_byte <= b;
        i_last_byte  <= last;
        do @(negedge i_clk); while (!o_in_ready);
        sb.note_frame_byte(b, last);
        @(posedge i_clk);
    endtask

    function automatic int frame_len_needed(logic [15:0] etype, logic [7:0] vbyte,
                                            logic [7:0] l4);
        bit v6;
        bit icmp;
        int ts;
        v6   = etype == ETH_IPV6;
        icmp = l4 == PROTO_ICMP || (v6 && l4 == PROTO_ICMPV6);
        ts   = v6 ? L3_START + V6_HDR_LEN : L3_START + 4 * vbyte[3:0];
        return ts + (icmp ? 2 : 4);
    endfunction

    // pad < 0 fills with random bytes, otherwise with that byte value
    task automatic send_frame_of(input logic [15:0] etype, input logic [7:0] vbyte,
                                 input logic [7:0] l4, input int len, input int pad);
        frame_bytes.delete();
        for (int i = 0; i < len; i++)
            frame_bytes.insert(frame_bytes.size(),
                               pad < 0 ? 8'($urandom_range(0, 255)) : 8'(pad));
        if (len > OFF_ETYPE_HI) frame_bytes[OFF_ETYPE_HI] = etype[15:8];
        if (len > OFF_ETYPE_LO) frame_bytes[OFF_ETYPE_LO] = etype[7:0];
        if (etype == ETH_IPV4 || etype == ETH_IPV6) begin
            if (len > L3_START) frame_bytes[L3_START] = vbyte;
            if (etype == ETH_IPV4 && len > L3_START + V4_PROTO_OFF)
                frame_bytes[L3_START + V4_PROTO_OFF] = l4;
            if (etype == ETH_IPV6 && len > L3_START + V6_PROTO_OFF)
                frame_bytes[L3_START + V6_PROTO_OFF] = l4;
        end
        for (int i = 0; i < len; i++) begin
            send_byte(frame_bytes[i], i == len - 1);
            bytes_sent++;
        end
        frames_sent++;
    endtask

    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_tuples.size() != 0);
    endtask

    function automatic logic [7:0] pick_l4(bit v6);
        case ($urandom_range(0, 5))
            0:       return PROTO_ICMP;
            1:       return PROTO_TCP;
            2:       return PROTO_UDP;
            3:       return PROTO_DCCP;
            4:       return PROTO_SCTP;
            default: return v6 ? PROTO_ICMPV6 : PROTO_TCP;
        endcase
    endfunction

    initial begin : stimulus
        logic [15:0] etype;
        logic [7:0]  vbyte;
        logic [7:0]  l4;
        int          full;
        int          len;
        int          pick;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: truncation points, odd ethertypes, IHL limits, every protocol
        send_frame_of(ETH_IPV4, 8'h45, PROTO_TCP, 1, -1);
        send_frame_of(ETH_IPV4, 8'h45, PROTO_TCP, 13, -1);
        send_frame_of(ETH_IPV4, 8'h45, PROTO_TCP, 14, -1);
        send_frame_of(16'h1234, 8'h45, PROTO_TCP, 60, -1);
        send_frame_of(16'h0000, 8'h00, 8'h00, 40, 0);
        send_frame_of(16'hffff, 8'hff, 8'hff, 40, 255);
        send_frame_of(ETH_IPV4, 8'h40, PROTO_TCP, 60, -1);
        send_frame_of(ETH_IPV4, 8'h44, PROTO_UDP, 60, -1);
        send_frame_of(ETH_IPV4, 8'h45, PROTO_TCP, 38, -1);
        send_frame_of(ETH_IPV4, 8'h4f, PROTO_UDP, 78, -1);
        send_frame_of(ETH_IPV4, 8'h45, PROTO_DCCP, 38, -1);
        send_frame_of(ETH_IPV4, 8'h45, PROTO_SCTP, 38, -1);
        send_frame_of(ETH_IPV4, 8'h45, PROTO_ICMP, 36, -1);
        send_frame_of(ETH_IPV4, 8'h45, PROTO_ICMPV6, 60, -1);
        send_frame_of(ETH_IPV4, 8'h45, PROTO_TCP, 23, -1);
        send_frame_of(ETH_IPV4, 8'h45, PROTO_ICMP, 24, -1);
        send_frame_of(ETH_IPV4, 8'h45, PROTO_TCP, 37, -1);
        send_frame_of(ETH_IPV6, 8'h60, PROTO_TCP, 58, -1);
        send_frame_of(ETH_IPV6, 8'h60, PROTO_ICMPV6, 56, -1);
        send_frame_of(ETH_IPV6, 8'h60, PROTO_ICMP, 56, -1);
        send_frame_of(ETH_IPV6, 8'h60, 8'hff, 60, -1);
        send_frame_of(ETH_IPV6, 8'h60, PROTO_UDP, 20, -1);
        send_frame_of(ETH_IPV6, 8'h60, PROTO_ICMPV6, 55, -1);
        send_frame_of(ETH_IPV4, 8'h45, PROTO_UDP, 150, -1);
        wait_all_results();

        // random frames, mostly well formed with random content
        for (int n = 0; bytes_sent < TOTAL_BYTES; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                etype = ETH_IPV4;
            else if (pick < 85)
                etype = ETH_IPV6;
            else
                etype = 16'($urandom_range(0, 16'hffff));
            vbyte = 8'($urandom_range(0, 255));
            if (etype == ETH_IPV4) begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    vbyte[3:0] = IHL_MIN;
                else if (pick < 90)
                    vbyte[3:0] = 4'($urandom_range(5, 15));
                else
                    vbyte[3:0] = 4'($urandom_range(0, 4));
            end
            l4 = ($urandom_range(0, 99) < 85) ? pick_l4(etype == ETH_IPV6)
                                              : 8'($urandom_range(0, 255));
            full = frame_len_needed(etype, vbyte, l4);
            pick = $urandom_range(0, 99);
            if (pick < 12)
                len = $urandom_range(1, full - 1);
            else if (pick < 16)
                len = $urandom_range(128, 150);
            else
                len = full + $urandom_range(0, 10);
            if (n == 1)
                hold_out = 1'b1;
            if (n == 3)
                wait_all_results();
            send_frame_of(etype, vbyte, l4, len, -1);
        end

        wait_all_results();
        repeat (SETTLE) @(posedge i_clk);
        $display("run covered %0d frames and %0d bytes, with stalls on both sides",
                 frames_sent, bytes_sent);
        $display("status seen: ok %0d, bad ethertype %0d, bad protocol %0d, malformed %0d",
                 sb.status_tally[ST_OK], sb.status_tally[ST_BAD_ETYPE],
                 sb.status_tally[ST_BAD_PROTO], sb.status_tally[ST_MALFORMED]);
        if (sb.errors == 0 && sb.expected_tuples.size() == 0) begin
            $display("PASS flow_tuple_extractor");
        end else begin
            $display("%0d errors, %0d results missing", sb.errors, sb.expected_tuples.size());
            $display("FAIL flow_tuple_extractor");
        end
        $finish;
    end

endmodule
